// ===== rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the Bezier curve evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS_DEF  = 32;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam logic [6:0] SCNT_RESET = 7'd64;

  localparam int CNT_W = 6;   // point count and point loop counters
  localparam int BIN_W = 30;  // binomial coefficients up to 33 points
  localparam int DIV_W = 40;  // dividend and quotient of the serial divider
  localparam int DVS_W = 7;   // divisor width
  localparam int MUL_W = 33;  // signed operand width of the shared multiplier

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [5:0]         sample_index;
    logic               last;
  } out_item_t;

endpackage

// ===== rtl/bce_ram.sv =====
// ----------------------------------------------------------------------------
// bce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bce_mul.sv =====
// ----------------------------------------------------------------------------
// bce_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module bce_mul
  import bce_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] q
);

  always_ff @(posedge clk) begin
    q <= a * b;
  end

endmodule

// ===== rtl/bce_div.sv =====
// ----------------------------------------------------------------------------
// bce_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bce_div
  import bce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CW'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DIV_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      // The remainder always stays below the divisor, so it fits DVS_W bits.
      if (!diff[DVS_W]) begin
        rem_r <= diff[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/bezier_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_evaluator
// Bernstein-form Bezier evaluation over a stored control point list.
// ----------------------------------------------------------------------------
// Add, clear and unused commands are handled in idle; busy stays low.
// An evaluation first builds the binomial row with the shared multiplier and
// the divider, then for each sample it divides for t (the final sample takes
// t = 1 directly), runs every point through the shared multiplier, and emits
// the result. One result strobe per sample; the receiver cannot stall. Reset is
// synchronous: point count zero, sample_count 64, no evaluation running.
module bezier_curve_evaluator
  import bce_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int TF  = T_FRAC_BITS;
  localparam int TW  = TF + 1;
  localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;
  localparam logic [63:0]   HALF  = 64'd1 << (TF - 1);
  localparam logic [62:0]   R_ONE = 63'd1 << 62;
  localparam logic [40:0]   W_ONE = 41'd1 << 40;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_BWR  = 19'h00002,
    S_BMUL = 19'h00004,
    S_BDIV = 19'h00008,
    S_SAMP = 19'h00010,
    S_TDIV = 19'h00020,
    S_PNT  = 19'h00040,
    S_M1   = 19'h00080,
    S_M2   = 19'h00100,
    S_M3   = 19'h00200,
    S_W1   = 19'h00400,
    S_W2   = 19'h00800,
    S_W3   = 19'h01000,
    S_A1   = 19'h02000,
    S_A2   = 19'h04000,
    S_A3   = 19'h08000,
    S_A4   = 19'h10000,
    S_A5   = 19'h20000,
    S_EMIT = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [6:0]       scnt_r;
  logic [5:0]       sm1_r, sm1_nxt;
  logic [5:0]       i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [BIN_W-1:0] binom_r, binom_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  logic [62:0]      r_r, r_nxt;
  logic [63:0]      ph_r, ph_nxt;
  logic [40:0]      w_r, w_nxt;
  logic signed [63:0] acc_x_r, acc_x_nxt;
  logic signed [63:0] acc_y_r, acc_y_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_q;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  logic [15:0]      x_rd, y_rd;
  logic [BIN_W-1:0] b_rd;
  logic             pt_we;
  logic             b_we;

  logic [TW-1:0]    u_val;
  logic [TW-1:0]    a_val;
  logic [63:0]      frac_sum;
  logic [63:0]      wraw;
  logic [6:0]       s_eff;
  logic [63:0]      rx, ry;

  assign u_val    = T_ONE - t_r;
  assign a_val    = (k_r < j_r) ? t_r : u_val;
  assign frac_sum = (ph_r << (31 - TF)) + ((mul_q[63:0] + HALF) >> TF);
  assign wraw     = (ph_r << 9) + ((mul_q[63:0] + 64'd2097152) >> 22);

  always_comb begin
    if (scnt_r < 7'd2) begin
      s_eff = 7'd2;
    end else if (scnt_r > 7'(MAX_SAMPLES)) begin
      s_eff = 7'(MAX_SAMPLES);
    end else begin
      s_eff = scnt_r;
    end
  end

  bce_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(pt_we), .waddr(cnt_r[PIW-1:0]), .wdata(in_data.px),
    .raddr(j_r[PIW-1:0]), .rdata(x_rd)
  );

  bce_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(pt_we), .waddr(cnt_r[PIW-1:0]), .wdata(in_data.py),
    .raddr(j_r[PIW-1:0]), .rdata(y_rd)
  );

  bce_ram #(.WIDTH(BIN_W), .DEPTH(MAX_POINTS)) u_bram (
    .clk(clk), .we(b_we), .waddr(j_r[PIW-1:0]), .wdata(binom_r),
    .raddr(j_r[PIW-1:0]), .rdata(b_rd)
  );

  bce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q));

  bce_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quo)
  );

  assign pt_we = (state_r == S_IDLE) && start && (in_data.cmd == CMD_ADD)
                 && (cnt_r < CNT_W'(MAX_POINTS));
  assign b_we  = (state_r == S_BWR);

  // Multiplier operand selection per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_BWR: begin
        mul_a = $signed(MUL_W'(binom_r));
        mul_b = $signed(MUL_W'(n_r - j_r));
      end
      S_M1: begin
        mul_a = $signed(MUL_W'(r_r[62:31]));
        mul_b = $signed(MUL_W'(a_val));
      end
      S_M2: begin
        mul_a = $signed(MUL_W'(r_r[30:0]));
        mul_b = $signed(MUL_W'(a_val));
      end
      S_W1: begin
        mul_a = $signed(MUL_W'(b_rd));
        mul_b = $signed(MUL_W'(r_r[62:31]));
      end
      S_W2: begin
        mul_a = $signed(MUL_W'(b_rd));
        mul_b = $signed(MUL_W'(r_r[30:0]));
      end
      S_A1: begin
        mul_a = $signed(MUL_W'(w_r[30:0]));
        mul_b = {{(MUL_W-16){x_rd[15]}}, x_rd};
      end
      S_A2: begin
        mul_a = $signed(MUL_W'(w_r[40:31]));
        mul_b = {{(MUL_W-16){x_rd[15]}}, x_rd};
      end
      S_A3: begin
        mul_a = $signed(MUL_W'(w_r[30:0]));
        mul_b = {{(MUL_W-16){y_rd[15]}}, y_rd};
      end
      S_A4: begin
        mul_a = $signed(MUL_W'(w_r[40:31]));
        mul_b = {{(MUL_W-16){y_rd[15]}}, y_rd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start    = (state_r == S_BMUL) || ((state_r == S_SAMP) && (i_r != sm1_r));
  assign div_dividend = (state_r == S_BMUL) ? mul_q[DIV_W-1:0]
                      : ((DIV_W'(i_r) << TF) + DIV_W'(sm1_r[5:1]));
  assign div_divisor  = (state_r == S_BMUL) ? DVS_W'(j_r + CNT_W'(1)) : DVS_W'(sm1_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sm1_nxt   = sm1_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    binom_nxt = binom_r;
    t_nxt     = t_r;
    r_nxt     = r_r;
    ph_nxt    = ph_r;
    w_nxt     = w_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.cmd)
            CMD_ADD: begin
              if (cnt_r < CNT_W'(MAX_POINTS)) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: cnt_nxt = '0;
            CMD_EVAL: begin
              sm1_nxt   = 6'(s_eff - 7'd1);
              i_nxt     = '0;
              j_nxt     = '0;
              n_nxt     = cnt_r - CNT_W'(1);
              binom_nxt = BIN_W'(1);
              state_nxt = (cnt_r == '0) ? S_SAMP : S_BWR;
            end
            default: ;
          endcase
        end
      end
      S_BWR: begin
        if (j_r == n_r) begin
          j_nxt     = '0;
          state_nxt = S_SAMP;
        end else begin
          state_nxt = S_BMUL;
        end
      end
      S_BMUL: state_nxt = S_BDIV;
      S_BDIV: begin
        if (div_done) begin
          binom_nxt = div_quo[BIN_W-1:0];
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_BWR;
        end
      end
      S_SAMP: begin
        acc_x_nxt = '0;
        acc_y_nxt = '0;
        j_nxt     = '0;
        if (i_r == sm1_r) begin
          t_nxt     = T_ONE;
          state_nxt = (cnt_r == '0) ? S_EMIT : S_PNT;
        end else begin
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          t_nxt     = div_quo[TW-1:0];
          state_nxt = (cnt_r == '0) ? S_EMIT : S_PNT;
        end
      end
      S_PNT: begin
        r_nxt     = R_ONE;
        k_nxt     = '0;
        state_nxt = (n_r == '0) ? S_W1 : S_M1;
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        ph_nxt    = mul_q[63:0];
        state_nxt = S_M3;
      end
      S_M3: begin
        r_nxt     = frac_sum[62:0];
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = (k_r + CNT_W'(1) == n_r) ? S_W1 : S_M1;
      end
      S_W1: state_nxt = S_W2;
      S_W2: begin
        ph_nxt    = mul_q[63:0];
        state_nxt = S_W3;
      end
      S_W3: begin
        w_nxt     = (wraw > 64'(W_ONE)) ? W_ONE : wraw[40:0];
        state_nxt = S_A1;
      end
      S_A1: state_nxt = S_A2;
      S_A2: begin
        acc_x_nxt = acc_x_r + mul_q[63:0];
        state_nxt = S_A3;
      end
      S_A3: begin
        acc_x_nxt = acc_x_r + {mul_q[32:0], 31'd0};
        state_nxt = S_A4;
      end
      S_A4: begin
        acc_y_nxt = acc_y_r + mul_q[63:0];
        state_nxt = S_A5;
      end
      S_A5: begin
        acc_y_nxt = acc_y_r + {mul_q[32:0], 31'd0};
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = (j_r == n_r) ? S_EMIT : S_PNT;
      end
      S_EMIT: begin
        i_nxt     = i_r + 6'd1;
        state_nxt = (i_r == sm1_r) ? S_IDLE : S_SAMP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Round Q.40 to Q.8 by adding one half and dropping 32 bits.
  assign rx = acc_x_r + 64'sd2147483648;
  assign ry = acc_y_r + 64'sd2147483648;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scnt_r      <= SCNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == S_EMIT);
      if (cfg_valid) begin
        scnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sm1_r   <= sm1_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    n_r     <= n_nxt;
    binom_r <= binom_nxt;
    t_r     <= t_nxt;
    r_r     <= r_nxt;
    ph_r    <= ph_nxt;
    w_r     <= w_nxt;
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
    if (state_r == S_EMIT) begin
      out_data_r.cx           <= rx[55:32];
      out_data_r.cy           <= ry[55:32];
      out_data_r.sample_index <= i_r;
      out_data_r.last         <= (i_r == sm1_r);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bce_checker.sv =====
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks for the Bezier curve evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bce_checker
  import bce_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // A result that is not the final one belongs to a running evaluation.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-final result while not busy");

  // Each sample takes many cycles, so results never come back to back.
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // Add, clear and unused commands finish in their own cycle.
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd != CMD_EVAL) |=> !busy && !out_valid)
    else $error("non-evaluate command kept the block busy");

  // An evaluation always occupies the block.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == CMD_EVAL) |=> busy)
    else $error("evaluate did not start");

  // Reset leaves the block idle and silent.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);
